// ===== rtl/irem_pkg.sv =====
// irem_pkg: shared types and constants of the integer remainder unit
// no dependencies; used by the interfaces, the iteration stage and the top level
`default_nettype none

package irem_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_S32_32 = 2'd0,
        KIND_S32_16 = 2'd1,
        KIND_S16_32 = 2'd2,
        KIND_U32_16 = 2'd3
    } kind_t;

    // one transaction in flight through the shift-and-subtract pipeline
    typedef struct packed {
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] part;
        logic              neg;
        logic              narrow;
        logic              zero;
    } work_t;

endpackage

`default_nettype wire

// ===== rtl/irem_if.sv =====
// irem_req_if, irem_rsp_if: valid/ready channels of the remainder unit
// depends on irem_pkg for field widths
`default_nettype none

interface irem_req_if;
    logic                          valid;
    logic                          ready;
    logic [irem_pkg::KIND_W-1:0]   kind;
    logic [irem_pkg::DATA_W-1:0]   dividend;
    logic [irem_pkg::DATA_W-1:0]   divisor;

    modport source (output valid, kind, dividend, divisor, input ready);
    modport sink   (input valid, kind, dividend, divisor, output ready);
endinterface

interface irem_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [irem_pkg::DATA_W-1:0]   remainder;
    logic                          divide_by_zero;

    modport source (output valid, remainder, divide_by_zero, input ready);
    modport sink   (input valid, remainder, divide_by_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/integer_remainder_unit.sv =====
// integer_remainder_unit: pipelined signed/unsigned 32-bit remainder
// depends on irem_pkg, irem_req_if, irem_rsp_if and irem_stage
// a request passes the preparation register, the iteration stages and the output register
// one request per cycle unless stalled; each stage runs STEPS_PER_STAGE subtract steps
// a stall holds the output and full stages behind it; empty upstream stages keep filling
// reset (rst_n low, asynchronous) clears every valid bit; payload registers are not reset
`default_nettype none

module integer_remainder_unit #(
    parameter int STEPS_PER_STAGE = 2   // must divide 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    irem_req_if.sink     req,
    irem_rsp_if.source   rsp
);
    import irem_pkg::*;

    localparam int NUM_STAGES = DATA_W / STEPS_PER_STAGE;

    function automatic logic [DATA_W-1:0] sext16(input logic [DATA_W-1:0] v);
        return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction

    // ------------------------------------------------------------------
    // operand preparation stage: pick the effective operands per mode,
    // take magnitudes for the signed modes, flag a zero divisor
    // ------------------------------------------------------------------
    logic  prep_valid_reg;
    work_t prep_reg;
    work_t prep_next;
    logic  prep_ready;

    always_comb
    begin
        logic [DATA_W-1:0] a_ext;
        logic [DATA_W-1:0] b_ext;
        logic              is_signed;
        a_ext     = req.dividend;
        b_ext     = req.divisor;
        is_signed = 1'b1;
        prep_next = '0;
        unique case (kind_t'(req.kind))
            KIND_S32_32:
            begin
                prep_next.narrow = 1'b0;
            end
            KIND_S32_16:
            begin
                b_ext            = sext16(req.divisor);
                prep_next.narrow = 1'b1;
            end
            KIND_S16_32:
            begin
                a_ext            = sext16(req.dividend);
                prep_next.narrow = 1'b1;
            end
            KIND_U32_16:
            begin
                b_ext            = {{(DATA_W-HALF_W){1'b0}}, req.divisor[HALF_W-1:0]};
                is_signed        = 1'b0;
                prep_next.narrow = 1'b1;
            end
            default:
            begin
                prep_next.narrow = 1'b0;
            end
        endcase
        // the most negative value negates to itself, read as unsigned 0x80000000
        prep_next.num  = (is_signed && a_ext[DATA_W-1]) ? (~a_ext + 1'b1) : a_ext;
        prep_next.den  = (is_signed && b_ext[DATA_W-1]) ? (~b_ext + 1'b1) : b_ext;
        prep_next.part = '0;
        prep_next.neg  = is_signed && a_ext[DATA_W-1];
        prep_next.zero = (b_ext == '0);
    end

    assign req.ready = !prep_valid_reg || prep_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            prep_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            prep_reg <= prep_next;
        end
    end

    // ------------------------------------------------------------------
    // shift-and-subtract pipeline: a zero divisor subtracts nothing, so
    // the partial remainder ends equal to the magnitude of the dividend
    // ------------------------------------------------------------------
    logic  chain_valid [NUM_STAGES+1];
    logic  chain_ready [NUM_STAGES+1];
    work_t chain_data  [NUM_STAGES+1];

    assign chain_valid[0] = prep_valid_reg;
    assign chain_data[0]  = prep_reg;
    assign prep_ready     = chain_ready[0];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        irem_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[s]),
            .up_ready (chain_ready[s]),
            .up_data  (chain_data[s]),
            .dn_valid (chain_valid[s+1]),
            .dn_ready (chain_ready[s+1]),
            .dn_data  (chain_data[s+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: restore the dividend's sign, narrow the 16-bit modes
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic              zero_reg;
    work_t             fin;

    assign fin = chain_data[NUM_STAGES];

    always_comb
    begin
        logic [DATA_W-1:0] r;
        r        = fin.neg ? (~fin.part + 1'b1) : fin.part;
        rem_next = fin.narrow ? sext16(r) : r;
    end

    assign chain_ready[NUM_STAGES] = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (chain_ready[NUM_STAGES])
        begin
            out_valid_reg <= chain_valid[NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_ready[NUM_STAGES] && chain_valid[NUM_STAGES])
        begin
            rem_reg  <= rem_next;
            zero_reg <= fin.zero;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.remainder      = rem_reg;
    assign rsp.divide_by_zero = zero_reg;

endmodule

`default_nettype wire

// ===== rtl/irem_stage.sv =====
// irem_stage: one register stage running STEPS restoring shift-and-subtract steps
// depends on irem_pkg (work_t)
`default_nettype none

module irem_stage #(
    parameter int STEPS = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire irem_pkg::work_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output irem_pkg::work_t      dn_data
);
    import irem_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    // bubbles collapse: a stage takes new data when empty or draining
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        logic top;
        data_next = up_data;
        for (int k = 0; k < STEPS; k++)
        begin
            top            = data_next.num[DATA_W-1];
            data_next.num  = {data_next.num[DATA_W-2:0], 1'b0};
            data_next.part = {data_next.part[DATA_W-2:0], top};
            if (data_next.den <= data_next.part)
            begin
                data_next.part = data_next.part - data_next.den;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
